>>> src/bse_pkg.sv
package bse_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PTR_W  = $clog2(DEPTH + 2);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

>>> src/bse_if.sv
interface bse_load_if;
  logic                              valid;
  logic                              ready;
  logic signed [bse_pkg::DATA_W-1:0] value;
  logic                              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface bse_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [bse_pkg::DATA_W-1:0] sorted_value;
  logic                              end_of_set;
  logic                              overflow;

  modport source (output valid, output sorted_value, output end_of_set, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_set, input overflow,
                  output ready);
endinterface

>>> src/bse_ram.sv
module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bubble_sort_engine.sv
// bubble sort engine: collects a set of signed 32-bit values, one per load item, until
// an item marked last arrives, sorts them ascending and returns them on the result
// channel in order, the final one marked end_of_set. up to 16 values are kept; further
// items are dropped and every result of that set then carries overflow. a dropped item
// marked last still closes the set. loading accepts one item per cycle. sorting runs on a
// single-port-read buffer memory with a carry register holding the running maximum of a
// pass, and a set of n values is sorted in n - 1 passes (none for a single value).
// emission then reads the buffer once per result, alternating between ST_EMIT_RD and
// ST_EMIT_LD and waiting in ST_EMIT_RD while the output register is full and not taken. no
// load item is taken between the last-marked item and the hand-off of the final result into
// the output register; the buffer needs no clearing pass after reset.
module bubble_sort_engine (
  input  logic             clk,
  input  logic             rst,
  bse_load_if.sink         load,
  bse_result_if.source     result
);

  bse_pkg::state_t state, state_next;

  // element count of the current set and drop status
  logic [bse_pkg::CNT_W-1:0]  count;
  logic                       dropped;

  // sort sequencing: pass number and position within a pass
  logic [bse_pkg::ADDR_W-1:0] pass;
  logic [bse_pkg::PTR_W-1:0]  ptr;
  logic signed [bse_pkg::DATA_W-1:0] carry;

  // emission index
  logic [bse_pkg::ADDR_W-1:0] emit_idx;

  // buffer memory ports
  logic                              ram_we;
  logic [bse_pkg::ADDR_W-1:0]        ram_waddr;
  logic [bse_pkg::DATA_W-1:0]        ram_wdata;
  logic [bse_pkg::ADDR_W-1:0]        ram_raddr;
  logic [bse_pkg::DATA_W-1:0]        ram_rdata;
  logic signed [bse_pkg::DATA_W-1:0] rd_value;

  logic                       load_acc;
  logic                       has_room;
  logic [bse_pkg::CNT_W-1:0]  count_after;
  logic [bse_pkg::PTR_W-1:0]  n_ext;
  logic                       cmp_swap;
  logic                       pass_end;
  logic                       last_pass;
  logic                       emit_last;
  logic                       emit_go;

  assign rd_value    = $signed(ram_rdata);
  assign load_acc    = load.valid && load.ready;
  assign has_room    = count < bse_pkg::CNT_W'(bse_pkg::DEPTH);
  assign count_after = has_room ? count + bse_pkg::CNT_W'(1) : count;
  assign n_ext       = bse_pkg::PTR_W'(count);
  // left value strictly greater: the smaller one settles, the larger one travels on
  assign cmp_swap    = carry > rd_value;
  assign pass_end    = ptr == n_ext + bse_pkg::PTR_W'(1);
  assign last_pass   = pass == bse_pkg::ADDR_W'(count - bse_pkg::CNT_W'(2));
  assign emit_last   = emit_idx == bse_pkg::ADDR_W'(count - bse_pkg::CNT_W'(1));
  // output register is free now or is emptied at this edge
  assign emit_go     = !result.valid || result.ready;

  bse_ram #(
    .WIDTH (bse_pkg::DATA_W),
    .DEPTH (bse_pkg::DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bse_pkg::ST_LOAD: begin
        if (load_acc && load.last) begin
          state_next = (count_after > bse_pkg::CNT_W'(1)) ? bse_pkg::ST_SORT
                                                          : bse_pkg::ST_EMIT_RD;
        end
      end
      bse_pkg::ST_SORT: begin
        if (pass_end && last_pass) begin
          state_next = bse_pkg::ST_EMIT_RD;
        end
      end
      bse_pkg::ST_EMIT_RD: begin
        if (emit_go) begin
          state_next = bse_pkg::ST_EMIT_LD;
        end
      end
      bse_pkg::ST_EMIT_LD: begin
        state_next = emit_last ? bse_pkg::ST_LOAD : bse_pkg::ST_EMIT_RD;
      end
      default: state_next = bse_pkg::ST_LOAD;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    load.ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = count[bse_pkg::ADDR_W-1:0];
    ram_wdata  = load.value;
    ram_raddr  = emit_idx;
    unique case (state)
      bse_pkg::ST_LOAD: begin
        load.ready = 1'b1;
        ram_we     = load_acc && has_room;
      end
      bse_pkg::ST_SORT: begin
        ram_raddr = ptr[bse_pkg::ADDR_W-1:0];
        if (pass_end) begin
          // travelling maximum lands in the top entry
          ram_we    = 1'b1;
          ram_waddr = bse_pkg::ADDR_W'(count - bse_pkg::CNT_W'(1));
          ram_wdata = carry;
        end else if (ptr >= bse_pkg::PTR_W'(2)) begin
          ram_we    = 1'b1;
          ram_waddr = bse_pkg::ADDR_W'(ptr - bse_pkg::PTR_W'(2));
          ram_wdata = cmp_swap ? rd_value : carry;
        end
      end
      bse_pkg::ST_EMIT_RD: begin
        ram_raddr = emit_idx;
      end
      bse_pkg::ST_EMIT_LD: begin
        ram_raddr = emit_idx;
      end
      default: begin
        load.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bse_pkg::ST_LOAD;
      count        <= '0;
      dropped      <= 1'b0;
      pass         <= '0;
      ptr          <= '0;
      emit_idx     <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;

      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        bse_pkg::ST_LOAD: begin
          if (load_acc) begin
            count <= count_after;
            if (!has_room) begin
              dropped <= 1'b1;
            end
          end
          pass     <= '0;
          ptr      <= '0;
          emit_idx <= '0;
        end
        bse_pkg::ST_SORT: begin
          if (pass_end) begin
            ptr  <= '0;
            pass <= pass + bse_pkg::ADDR_W'(1);
          end else begin
            ptr <= ptr + bse_pkg::PTR_W'(1);
          end
          // first read of a pass seeds the carry
          if (ptr == bse_pkg::PTR_W'(1)) begin
            carry <= rd_value;
          end else if (ptr >= bse_pkg::PTR_W'(2) && !pass_end && !cmp_swap) begin
            carry <= rd_value;
          end
        end
        bse_pkg::ST_EMIT_RD: begin
        end
        bse_pkg::ST_EMIT_LD: begin
          result.valid <= 1'b1;
          result.sorted_value <= rd_value;
          result.end_of_set   <= emit_last;
          result.overflow     <= dropped;
          if (emit_last) begin
            count   <= '0;
            dropped <= 1'b0;
          end else begin
            emit_idx <= emit_idx + bse_pkg::ADDR_W'(1);
          end
        end
        default: begin
          count <= '0;
        end
      endcase
    end
  end

endmodule
